// ===== rtl/mrim_pkg.sv =====
// Package for the match run insertion merge block: result record type,
// record kind codes and result queue sizing. It depends on nothing else.
package mrim_pkg;

    localparam int unsigned POS_W = 32;
    localparam int unsigned LEN_W = 32;
    localparam int unsigned CHAR_W = 8;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // The queue depth must be a power of two so that the pointers wrap on their own.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [CHAR_W-1:0] ref_char;
        logic [CHAR_W-1:0] tgt_char;
        logic              end_of_run;
    } result_t;

endpackage

// ===== rtl/mrim_res_fifo.sv =====
// Result queue for the match run insertion merge block: takes up to two
// records a cycle and presents one registered record a cycle while out_ready is high. Uses mrim_pkg.
module mrim_res_fifo
    import mrim_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_a,
    input  result_t data_a,
    input  logic    push_b,
    input  result_t data_b,
    output logic    space_two,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wr_ptr_b;
    logic [1:0]         n_push;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign n_push    = {1'b0, push_a} + {1'b0, push_b};
    assign wr_ptr_b  = push_a ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
    assign space_two = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem_reg[wr_ptr_reg] <= data_a;
        end
        if (push_b)
        begin
            mem_reg[wr_ptr_b] <= data_b;
        end
    end

endmodule

// ===== rtl/match_run_insertion_merge.sv =====
// Top level of the match run insertion merge block: run state and record
// decisions. Depends on mrim_pkg and mrim_res_fifo.
//
// Input channel (in_valid/in_ready) carries one match record per beat; the
// record marked is_last closes the sequence. Output channel
// (out_valid/out_ready) carries one result record per beat, either a merged
// match or an insertion, with end_of_run set on the final result.
// A record gives zero, one or two results. Its results are written into a
// four-entry queue at the accepting edge and are offered from its registered
// storage. A record is taken whenever the queue has room for two results, so
// one record a cycle is sustained while the receiver is ready and each record
// yields at most one result; the output port, one result a cycle, sets the
// rate otherwise. When the receiver stalls, the queue fills and in_ready
// falls once fewer than two entries are free; nothing is lost.
// Reset empties the queue and clears the run state, so the next record opens
// a new sequence. After each record marked last the run state is cleared too.
module match_run_insertion_merge
    import mrim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [POS_W-1:0]  match_pos,
    input  logic [LEN_W-1:0]  match_len,
    input  logic [CHAR_W-1:0] ref_char,
    input  logic [CHAR_W-1:0] tgt_char,
    input  logic              is_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [POS_W-1:0]  out_pos,
    output logic [LEN_W-1:0]  out_len,
    output logic [CHAR_W-1:0] out_ref_char,
    output logic [CHAR_W-1:0] out_tgt_char,
    output logic              end_of_run
);

    logic              first_pending_reg;
    logic              first_pending_next;
    logic [POS_W-1:0]  prev_start_reg;
    logic [POS_W-1:0]  prev_start_next;
    logic [LEN_W-1:0]  prev_length_reg;
    logic [LEN_W-1:0]  prev_length_next;
    logic [CHAR_W-1:0] prev_ref_reg;
    logic [CHAR_W-1:0] prev_ref_next;
    logic [CHAR_W-1:0] prev_tgt_reg;
    logic [CHAR_W-1:0] prev_tgt_next;
    logic [POS_W-1:0]  run_start_reg;
    logic [POS_W-1:0]  run_start_next;
    logic [LEN_W-1:0]  run_sum_reg;
    logic [LEN_W-1:0]  run_sum_next;
    logic [POS_W-1:0]  ins_pos_reg;
    logic [POS_W-1:0]  ins_pos_next;

    logic              accept;
    logic              adjacent;
    logic [POS_W-1:0]  new_run_start;
    logic [LEN_W-1:0]  new_run_sum;
    logic [POS_W-1:0]  new_ins_pos;
    logic              push_a;
    logic              push_b;
    result_t           res_a;
    result_t           res_b;
    logic              space_two;
    result_t           out_data;

    assign accept   = in_valid && in_ready;
    assign in_ready = space_two;
    assign adjacent = (prev_start_reg + prev_length_reg) == match_pos;

    always_comb
    begin
        if (first_pending_reg)
        begin
            new_run_start = match_pos;
            new_run_sum   = '0;
            new_ins_pos   = match_len;
        end
        else if (adjacent)
        begin
            new_run_start = run_start_reg;
            new_run_sum   = run_sum_reg + prev_length_reg;
            new_ins_pos   = ins_pos_reg + match_len + POS_W'(1);
        end
        else
        begin
            new_run_start = match_pos;
            new_run_sum   = '0;
            new_ins_pos   = ins_pos_reg + match_len + POS_W'(1);
        end

        res_a.ref_char   = prev_ref_reg;
        res_a.tgt_char   = prev_tgt_reg;
        res_a.end_of_run = 1'b0;
        if (adjacent)
        begin
            res_a.kind = KIND_INSERT;
            res_a.pos  = ins_pos_reg + POS_W'(1);
            res_a.len  = '0;
        end
        else
        begin
            res_a.kind = KIND_MATCH;
            res_a.pos  = run_start_reg;
            res_a.len  = run_sum_reg + prev_length_reg;
        end

        res_b.kind       = KIND_MATCH;
        res_b.pos        = new_run_start;
        res_b.len        = new_run_sum + match_len;
        res_b.ref_char   = ref_char;
        res_b.tgt_char   = tgt_char;
        res_b.end_of_run = 1'b1;

        push_a = accept && !first_pending_reg;
        push_b = accept && is_last;

        first_pending_next = first_pending_reg;
        prev_start_next    = prev_start_reg;
        prev_length_next   = prev_length_reg;
        prev_ref_next      = prev_ref_reg;
        prev_tgt_next      = prev_tgt_reg;
        run_start_next     = run_start_reg;
        run_sum_next       = run_sum_reg;
        ins_pos_next       = ins_pos_reg;
        if (accept)
        begin
            if (is_last)
            begin
                first_pending_next = 1'b1;
                prev_start_next    = '0;
                prev_length_next   = '0;
                prev_ref_next      = '0;
                prev_tgt_next      = '0;
                run_start_next     = '0;
                run_sum_next       = '0;
                ins_pos_next       = '0;
            end
            else
            begin
                first_pending_next = 1'b0;
                prev_start_next    = match_pos;
                prev_length_next   = match_len;
                prev_ref_next      = ref_char;
                prev_tgt_next      = tgt_char;
                run_start_next     = new_run_start;
                run_sum_next       = new_run_sum;
                ins_pos_next       = new_ins_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b1;
            prev_start_reg    <= '0;
            prev_length_reg   <= '0;
            prev_ref_reg      <= '0;
            prev_tgt_reg      <= '0;
            run_start_reg     <= '0;
            run_sum_reg       <= '0;
            ins_pos_reg       <= '0;
        end
        else
        begin
            first_pending_reg <= first_pending_next;
            prev_start_reg    <= prev_start_next;
            prev_length_reg   <= prev_length_next;
            prev_ref_reg      <= prev_ref_next;
            prev_tgt_reg      <= prev_tgt_next;
            run_start_reg     <= run_start_next;
            run_sum_reg       <= run_sum_next;
            ins_pos_reg       <= ins_pos_next;
        end
    end

    mrim_res_fifo u_res_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .data_a    (res_a),
        .push_b    (push_b),
        .data_b    (res_b),
        .space_two (space_two),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign out_pos      = out_data.pos;
    assign out_len      = out_data.len;
    assign out_ref_char = out_data.ref_char;
    assign out_tgt_char = out_data.tgt_char;
    assign end_of_run   = out_data.end_of_run;

endmodule

// ===== tb/sv/mrim_merge_checker.sv =====
// Checker for the match run insertion merge block: watches both channels,
// predicts the result records of every accepted record and compares them.
// Depends on mrim_pkg for the result record type and the kind codes.
module mrim_merge_checker
    import mrim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [POS_W-1:0]  match_pos,
    input  logic [LEN_W-1:0]  match_len,
    input  logic [CHAR_W-1:0] ref_char,
    input  logic [CHAR_W-1:0] tgt_char,
    input  logic              is_last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              kind,
    input  logic [POS_W-1:0]  out_pos,
    input  logic [LEN_W-1:0]  out_len,
    input  logic [CHAR_W-1:0] out_ref_char,
    input  logic [CHAR_W-1:0] out_tgt_char,
    input  logic              end_of_run,
    output int unsigned       failures,
    output int unsigned       outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    result_t expected_records[$];

    logic              run_open;
    logic [POS_W-1:0]  last_start;
    logic [LEN_W-1:0]  last_len;
    logic [CHAR_W-1:0] last_ref;
    logic [CHAR_W-1:0] last_tgt;
    logic [POS_W-1:0]  run_start;
    logic [LEN_W-1:0]  run_sum;
    logic [POS_W-1:0]  insert_pos;

    result_t     wanted;
    int unsigned bad_fields;

    function automatic result_t make_record(logic k, logic [POS_W-1:0] p,
                                            logic [LEN_W-1:0] l,
                                            logic [CHAR_W-1:0] rc,
                                            logic [CHAR_W-1:0] tc, logic eor);
        result_t r;
        r.kind = k;
        r.pos = p;
        r.len = l;
        r.ref_char = rc;
        r.tgt_char = tc;
        r.end_of_run = eor;
        return r;
    endfunction

    task automatic clear_run();
        run_open = 1'b0;
        last_start = '0;
        last_len = '0;
        last_ref = '0;
        last_tgt = '0;
        run_start = '0;
        run_sum = '0;
        insert_pos = '0;
    endtask

    // A record that starts where the previous match ended turns the previous
    // mismatch into an insertion; otherwise the open run is closed.
    task automatic predict_merge(logic [POS_W-1:0] pos, logic [LEN_W-1:0] len,
                                 logic [CHAR_W-1:0] rc, logic [CHAR_W-1:0] tc,
                                 logic last);
        logic [POS_W-1:0] prev_end;
        prev_end = last_start + last_len;
        if (!run_open)
        begin
            run_start = pos;
            run_sum = '0;
            insert_pos = len;
            run_open = 1'b1;
        end
        else
        begin
            if (prev_end == pos)
            begin
                run_sum = run_sum + last_len;
                expected_records.push_back(make_record(KIND_INSERT,
                                                       insert_pos + POS_W'(1), '0,
                                                       last_ref, last_tgt, 1'b0));
            end
            else
            begin
                expected_records.push_back(make_record(KIND_MATCH, run_start,
                                                       run_sum + last_len,
                                                       last_ref, last_tgt, 1'b0));
                run_start = pos;
                run_sum = '0;
            end
            insert_pos = insert_pos + len + POS_W'(1);
        end
        last_start = pos;
        last_len = len;
        last_ref = rc;
        last_tgt = tc;
        if (last)
        begin
            expected_records.push_back(make_record(KIND_MATCH, run_start, run_sum + len,
                                                   rc, tc, 1'b1));
            clear_run();
        end
    endtask

    function automatic int unsigned field_differs(string name, logic [31:0] exp_val,
                                                  logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_run();
            expected_records.delete();
            failures <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad_fields = 0;
            if (in_valid && in_ready)
            begin
                predict_merge(match_pos, match_len, ref_char, tgt_char, is_last);
            end
            if (out_valid && out_ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("result beat with no record expected: pos %0h len %0h",
                           out_pos, out_len);
                    bad_fields = 1;
                end
                else
                begin
                    wanted = expected_records.pop_front();
                    bad_fields += field_differs("kind", 32'(wanted.kind), 32'(kind));
                    bad_fields += field_differs("out_pos", wanted.pos, out_pos);
                    bad_fields += field_differs("out_len", wanted.len, out_len);
                    bad_fields += field_differs("out_ref_char", 32'(wanted.ref_char),
                                                32'(out_ref_char));
                    bad_fields += field_differs("out_tgt_char", 32'(wanted.tgt_char),
                                                32'(out_tgt_char));
                    bad_fields += field_differs("end_of_run", 32'(wanted.end_of_run),
                                                32'(end_of_run));
                end
            end
            if (bad_fields != 0)
            begin
                failures <= failures + 1;
            end
            outstanding <= expected_records.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench for the match run insertion merge block: clock,
// reset, record stimulus, channel idling and the final verdict.
// Depends on mrim_pkg, match_run_insertion_merge and mrim_merge_checker.
module testbench
    import mrim_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_RECORDS = 800;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid;
    logic              in_ready;
    logic [POS_W-1:0]  match_pos;
    logic [LEN_W-1:0]  match_len;
    logic [CHAR_W-1:0] ref_char;
    logic [CHAR_W-1:0] tgt_char;
    logic              is_last;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              kind;
    logic [POS_W-1:0]  out_pos;
    logic [LEN_W-1:0]  out_len;
    logic [CHAR_W-1:0] out_ref_char;
    logic [CHAR_W-1:0] out_tgt_char;
    logic              end_of_run;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned records_sent = 0;
    int unsigned quiet_cycles = 0;

    match_run_insertion_merge dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .match_pos    (match_pos),
        .match_len    (match_len),
        .ref_char     (ref_char),
        .tgt_char     (tgt_char),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_pos      (out_pos),
        .out_len      (out_len),
        .out_ref_char (out_ref_char),
        .out_tgt_char (out_tgt_char),
        .end_of_run   (end_of_run)
    );

    mrim_merge_checker merge_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .match_pos    (match_pos),
        .match_len    (match_len),
        .ref_char     (ref_char),
        .tgt_char     (tgt_char),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_pos      (out_pos),
        .out_len      (out_len),
        .out_ref_char (out_ref_char),
        .out_tgt_char (out_tgt_char),
        .end_of_run   (end_of_run),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_record(logic [POS_W-1:0] pos, logic [LEN_W-1:0] len,
                               logic [CHAR_W-1:0] rc, logic [CHAR_W-1:0] tc,
                               logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        match_pos <= pos;
        match_len <= len;
        ref_char <= rc;
        tgt_char <= tc;
        is_last <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        records_sent = records_sent + 1;
    endtask

    task automatic set_phase();
        case ((records_sent / 100) % 4)
            0:
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct = 46;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct = 0;
                stall_pct = 46;
            end
            default:
            begin
                idle_pct = 12;
                stall_pct = 12;
            end
        endcase
    endtask

    task automatic random_sequence();
        int unsigned      count;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] next_pos;
        next_pos = $urandom();
        count = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
        for (int unsigned i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: len = $urandom();
                1: len = '0;
                2: len = '1;
                default: len = $urandom_range(200);
            endcase
            if (i > 0 && $urandom_range(99) < 55)
            begin
                pos = next_pos;
            end
            else
            begin
                case ($urandom_range(3))
                    0: pos = $urandom();
                    1: pos = next_pos + $urandom_range(1, 50);
                    2: pos = next_pos - $urandom_range(1, 50);
                    default: pos = $urandom_range(1000);
                endcase
            end
            set_phase();
            send_record(pos, len, CHAR_W'($urandom_range(255)),
                        CHAR_W'($urandom_range(255)), i == count - 1);
            next_pos = pos + len;
        end
    endtask

    initial
    begin
        in_valid <= 1'b0;
        match_pos <= '0;
        match_len <= '0;
        ref_char <= '0;
        tgt_char <= '0;
        is_last <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-record sequences at both ends of every field.
        send_record('0, '0, '0, '0, 1'b1);
        send_record('1, '1, '1, '1, 1'b1);
        // Adjacency across the wrap of the position, zero-length matches,
        // a broken run and a last record that joins the run.
        send_record(32'hFFFF_FFF0, 32'h20, 8'h41, 8'h43, 1'b0);
        send_record(32'h10, 32'h5, 8'h47, 8'h54, 1'b0);
        send_record(32'h15, 32'h0, 8'h00, 8'hFF, 1'b0);
        send_record(32'h15, 32'h0, 8'hFF, 8'h00, 1'b0);
        send_record(32'h100, 32'h7, 8'h55, 8'hAA, 1'b0);
        send_record(32'h107, 32'h3, 8'hAA, 8'h55, 1'b1);
        // A last record that breaks the run gives two merged records.
        send_record(32'h5, 32'hA, 8'h01, 8'h02, 1'b0);
        send_record(32'h64, 32'h14, 8'h03, 8'h04, 1'b1);
        // Lengths large enough to wrap the run length and insertion position.
        send_record(32'h1, 32'hFFFF_FFFF, 8'h80, 8'h7F, 1'b0);
        send_record(32'h0, 32'hFFFF_FFFF, 8'h7F, 8'h80, 1'b0);
        send_record(32'hFFFF_FFFF, 32'h2, 8'hC3, 8'h3C, 1'b1);

        records_sent = 0;
        while (records_sent < RANDOM_RECORDS)
        begin
            random_sequence();
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
